>>> hdl/ibms_pkg.sv
// ----------------------------------------------------------------------------
// ibms_pkg
// Shared types and constants of the interval based motion scaler.
// ----------------------------------------------------------------------------
package ibms_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CODE_W     = 16;
  localparam int CODE_CNT_W = 3;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = 5;

  typedef logic        [7:0]  ev_type_t;
  typedef logic        [15:0] ev_code_t;
  typedef logic signed [15:0] ev_value_t;
  typedef logic        [31:0] tstamp_t;
  typedef logic        [15:0] gain_t;
  typedef logic        [15:0] ms_t;

  localparam gain_t RESET_GAIN = 16'd10;
  localparam ms_t   DIV_TEN    = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_TYPE = 3'd0,
    REG_CODE_TABLE = 3'd1,
    REG_CODES_USED = 3'd2,
    REG_MIN_GAIN   = 3'd3,
    REG_MAX_GAIN   = 3'd4,
    REG_FAST_BOUND = 3'd5,
    REG_SLOW_BOUND = 3'd6
  } cfg_reg_t;

endpackage

>>> hdl/ibms_in_if.sv
// ----------------------------------------------------------------------------
// ibms_in_if
// Motion event channel: valid/ready handshake with the event word.
// ----------------------------------------------------------------------------
interface ibms_in_if;
  import ibms_pkg::*;

  logic      valid;
  logic      ready;
  ev_type_t  event_type;
  ev_code_t  event_code;
  ev_value_t event_value;
  tstamp_t   timestamp_ms;
  logic      has_remainder;
  ev_value_t remainder_in;

  modport source (
    output valid, event_type, event_code, event_value, timestamp_ms,
           has_remainder, remainder_in,
    input  ready
  );

  modport sink (
    input  valid, event_type, event_code, event_value, timestamp_ms,
           has_remainder, remainder_in,
    output ready
  );
endinterface

>>> hdl/ibms_out_if.sv
// ----------------------------------------------------------------------------
// ibms_out_if
// Scaled result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface ibms_out_if;
  import ibms_pkg::*;

  logic      valid;
  logic      ready;
  ev_value_t value_out;
  ev_value_t remainder_out;
  logic      was_scaled;

  modport source (
    output valid, value_out, remainder_out, was_scaled,
    input  ready
  );

  modport sink (
    input  valid, value_out, remainder_out, was_scaled,
    output ready
  );
endinterface

>>> hdl/interval_based_motion_scaler_top.sv
// ----------------------------------------------------------------------------
// interval_based_motion_scaler_top
// Pointer acceleration: scales matching motion words by a gap dependent gain.
// ----------------------------------------------------------------------------
// One event word is taken at a time. A word that does not match type and code
// skips the computation and comes out unchanged. A matching word whose gap
// lies at or outside the fast/slow bounds takes one pass of the divider for the
// divide by ten; a gap strictly between the bounds adds an interpolation pass.
// The single radix-2 restoring divider (32 steps per pass) and the single
// 17x17 multiplier are both shared by the two halves of the computation. The
// result sits in an output register, so the next word is taken while a result
// still waits. Configuration is written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; the user must keep to this, the block does not
// enforce it. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module interval_based_motion_scaler_top #(
  parameter int MAX_CODES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ibms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ibms_in_if.sink                        in_ch,
  ibms_out_if.source                     out_ch
);
  import ibms_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_GAP,
    ST_IMUL,
    ST_DIV_SPAN,
    ST_GAIN,
    ST_VMUL,
    ST_SUM,
    ST_DIV_TEN,
    ST_ROUND,
    ST_FIN
  } state_t;

  // configuration registers
  ev_type_t                  match_type_r;
  logic [MAX_CODES*CODE_W-1:0] code_table_r;
  logic [CODE_CNT_W-1:0]     codes_in_use_r;
  gain_t                     min_gain_r;
  gain_t                     max_gain_r;
  ms_t                       fast_bound_r;
  ms_t                       slow_bound_r;

  // block state: time of the last scaled word, zero means none yet
  tstamp_t                   last_time_r;

  state_t                    state_r;

  // captured event word
  ev_type_t                  type_r;
  ev_code_t                  code_r;
  ev_value_t                 value_r;
  tstamp_t                   now_r;
  logic                      has_rem_r;
  ev_value_t                 rem_in_r;

  // working registers
  gain_t                     gain_r;
  gain_t                     gmag_r;     // |max_gain - min_gain|
  logic                      gneg_r;     // max_gain below min_gain
  ms_t                       pos_r;      // gap - fast bound
  logic signed [33:0]        prod_r;
  logic                      sum_neg_r;
  logic [DIV_W-1:0]          div_quo_r;  // dividend shifts out, quotient shifts in
  logic [15:0]               div_rem_r;
  ms_t                       divisor_r;
  logic [DIV_CNT_W-1:0]      div_cnt_r;

  // finished result waiting for the output register
  ev_value_t                 res_value_r;
  ev_value_t                 res_rem_r;
  logic                      res_scaled_r;

  // output register
  logic                      out_valid_r;
  ev_value_t                 out_value_r;
  ev_value_t                 out_rem_r;
  logic                      out_scaled_r;

  // ------------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_type_r   <= '0;
      code_table_r   <= '0;
      codes_in_use_r <= '0;
      min_gain_r     <= RESET_GAIN;
      max_gain_r     <= RESET_GAIN;
      fast_bound_r   <= '0;
      slow_bound_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MATCH_TYPE: match_type_r   <= cfg_wdata[7:0];
        REG_CODE_TABLE: code_table_r   <= cfg_wdata[MAX_CODES*CODE_W-1:0];
        REG_CODES_USED: codes_in_use_r <= cfg_wdata[CODE_CNT_W-1:0];
        REG_MIN_GAIN:   min_gain_r     <= cfg_wdata[15:0];
        REG_MAX_GAIN:   max_gain_r     <= cfg_wdata[15:0];
        REG_FAST_BOUND: fast_bound_r   <= cfg_wdata[15:0];
        REG_SLOW_BOUND: slow_bound_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // type and code match; a use count above MAX_CODES saturates by itself
  // ------------------------------------------------------------------------
  logic code_hit;
  logic word_hit;

  always_comb begin
    code_hit = 1'b0;
    for (int i = 0; i < MAX_CODES; i++) begin
      if ((codes_in_use_r > CODE_CNT_W'(i)) &&
          (code_table_r[i*CODE_W +: CODE_W] == code_r)) begin
        code_hit = 1'b1;
      end
    end
  end

  assign word_hit = (type_r == match_type_r) && code_hit;

  // ------------------------------------------------------------------------
  // gap since last scaled word, clamped at zero; first word counts as slow
  // ------------------------------------------------------------------------
  logic [32:0] gap_diff;
  tstamp_t     gap;
  logic        gap_fast;
  logic        gap_slow;

  assign gap_diff = {1'b0, now_r} - {1'b0, last_time_r};

  always_comb begin
    if (last_time_r == '0) begin
      gap = {16'd0, slow_bound_r};
    end else if (gap_diff[32]) begin
      gap = '0;
    end else begin
      gap = gap_diff[31:0];
    end
  end

  // fast test first, so a gap that meets both inverted bounds gives the max gain
  assign gap_fast = gap <= {16'd0, fast_bound_r};
  assign gap_slow = gap >= {16'd0, slow_bound_r};

  // ------------------------------------------------------------------------
  // shared multiplier: gain span times position, then value times gain
  // ------------------------------------------------------------------------
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    if (state_r == ST_IMUL) begin
      mul_a = $signed({1'b0, gmag_r});
      mul_b = $signed({1'b0, pos_r});
    end else begin
      mul_a = $signed({value_r[15], value_r});
      mul_b = $signed({1'b0, gain_r});
    end
  end

  assign mul_p = mul_a * mul_b;

  // ------------------------------------------------------------------------
  // product plus carried remainder, split into sign and magnitude
  // ------------------------------------------------------------------------
  logic signed [33:0] sum_w;
  logic        [33:0] sum_mag;

  assign sum_w   = prod_r + (has_rem_r ? {{18{rem_in_r[15]}}, rem_in_r} : 34'sd0);
  assign sum_mag = sum_w[33] ? (~sum_w + 34'd1) : sum_w;

  // ------------------------------------------------------------------------
  // shared divider, one quotient bit per cycle
  // ------------------------------------------------------------------------
  logic [16:0]      div_shift;
  logic [17:0]      div_trial;
  logic             div_take;
  logic [15:0]      div_rem_nxt;
  logic [DIV_W-1:0] div_quo_nxt;
  logic             div_last;

  assign div_shift   = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_trial   = {1'b0, div_shift} - {2'b00, divisor_r};
  assign div_take    = !div_trial[17];
  assign div_rem_nxt = div_take ? div_trial[15:0] : div_shift[15:0];
  assign div_quo_nxt = {div_quo_r[DIV_W-2:0], div_take};
  assign div_last    = div_cnt_r == DIV_CNT_W'(DIV_W - 1);

  // interpolated gain, truncation toward zero through the sign of the span
  gain_t gain_interp;
  assign gain_interp = gneg_r ? (max_gain_r + div_quo_r[15:0])
                              : (max_gain_r - div_quo_r[15:0]);

  // signed quotient and remainder of the divide by ten, wrapped to 16 bits
  ev_value_t quot_nxt;
  ev_value_t rem_nxt;
  assign quot_nxt = sum_neg_r ? (~div_quo_r[15:0] + 16'd1) : div_quo_r[15:0];
  assign rem_nxt  = sum_neg_r ? (~div_rem_r + 16'd1) : div_rem_r;

  logic in_take;
  logic out_free;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // ------------------------------------------------------------------------
  // sequencer and output register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_time_r <= '0;
      div_cnt_r   <= '0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            type_r    <= in_ch.event_type;
            code_r    <= in_ch.event_code;
            value_r   <= in_ch.event_value;
            now_r     <= in_ch.timestamp_ms;
            has_rem_r <= in_ch.has_remainder;
            rem_in_r  <= in_ch.remainder_in;
            state_r   <= ST_MATCH;
          end
        end

        ST_MATCH: begin
          // pass-through word unless the match holds
          res_value_r  <= value_r;
          res_rem_r    <= rem_in_r;
          res_scaled_r <= 1'b0;
          state_r      <= word_hit ? ST_GAP : ST_FIN;
        end

        ST_GAP: begin
          last_time_r <= now_r;
          gneg_r      <= max_gain_r < min_gain_r;
          gmag_r      <= (max_gain_r < min_gain_r) ? (min_gain_r - max_gain_r)
                                                   : (max_gain_r - min_gain_r);
          pos_r       <= gap[15:0] - fast_bound_r;
          divisor_r   <= slow_bound_r - fast_bound_r;
          if (gap_fast) begin
            gain_r  <= max_gain_r;
            state_r <= ST_VMUL;
          end else if (gap_slow) begin
            gain_r  <= min_gain_r;
            state_r <= ST_VMUL;
          end else begin
            state_r <= ST_IMUL;
          end
        end

        ST_IMUL: begin
          // both factors nonnegative, product below 2^32
          div_quo_r <= mul_p[DIV_W-1:0];
          div_rem_r <= '0;
          div_cnt_r <= '0;
          state_r   <= ST_DIV_SPAN;
        end

        ST_DIV_SPAN: begin
          div_quo_r <= div_quo_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_last) begin
            state_r <= ST_GAIN;
          end
        end

        ST_GAIN: begin
          gain_r  <= gain_interp;
          state_r <= ST_VMUL;
        end

        ST_VMUL: begin
          prod_r  <= mul_p;
          state_r <= ST_SUM;
        end

        ST_SUM: begin
          // magnitude at most 2^31, fits the divider
          sum_neg_r <= sum_w[33];
          div_quo_r <= sum_mag[DIV_W-1:0];
          div_rem_r <= '0;
          divisor_r <= DIV_TEN;
          div_cnt_r <= '0;
          state_r   <= ST_DIV_TEN;
        end

        ST_DIV_TEN: begin
          div_quo_r <= div_quo_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_last) begin
            state_r <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          res_value_r  <= quot_nxt;
          res_scaled_r <= 1'b1;
          if (has_rem_r) begin
            res_rem_r <= rem_nxt;
          end
          state_r <= ST_FIN;
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_value_r;
            out_rem_r    <= res_rem_r;
            out_scaled_r <= res_scaled_r;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = state_r == ST_IDLE;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.value_out     = out_value_r;
  assign out_ch.remainder_out = out_rem_r;
  assign out_ch.was_scaled    = out_scaled_r;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  // an accepted word always starts the sequencer
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_MATCH)
    else $error("accepted word did not start the sequencer");

  // interpolation quotient never exceeds the gain span
  a_interp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GAIN |-> div_quo_r <= {16'd0, gmag_r})
    else $error("interpolation quotient beyond gain span");

  // remainder of the divide by ten stays below ten
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> div_rem_r < DIV_TEN)
    else $error("remainder of divide by ten out of range");

  // a new result word only comes from the final state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result word raised outside the final state");

endmodule
